>>> rtl/decimal_number_text_parser_top_defines.svh
// Assertion macros used by the checker file of the number text parser.
`ifndef DECIMAL_NUMBER_TEXT_PARSER_TOP_DEFINES_SVH
`define DECIMAL_NUMBER_TEXT_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DNTP_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DNTP_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

>>> rtl/dntp_pkg.sv
`default_nettype none
package dntp_pkg;

  localparam int MANTISSA_BITS = 32;
  localparam int EXPONENT_BITS = 8;

  // Width of the signed power of ten before it is cut to the output field.
  localparam int DEXP_W = ((EXPONENT_BITS > 7) ? EXPONENT_BITS : 7) + 2;

  localparam int FRAC_W = 6;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 6'd63;

  localparam int OUT_MANT_W = 32;
  localparam int OUT_DEXP_W = 10;
  localparam int OUT_DATA_W = 48;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SYNTAX   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic point;
    logic exp;
    logic minus;
    logic plus;
    logic neg;
    logic exp_neg;
    logic exp_digit;
  } phase_flags_t;

endpackage
`default_nettype wire

>>> rtl/decimal_number_text_parser_top.sv
// Decimal number text parser.
// Input stream (s_*): one ASCII character per transfer in s_tdata[7:0]. A NUL
// ends the text and yields exactly one result; other characters yield none.
// Output stream (m_*): one result per text. m_tuser carries the status
// (0 valid, 1 syntax error, 2 overflow); m_tdata carries is_negative, the
// joined integer/fraction digits as mantissa and the signed power of ten.
// The result appears on m_tvalid in the cycle after the NUL transfer.
// Throughput: one character per cycle unless stalled; each one passes a single
// multiply-by-ten accumulate and flag update into the parser state registers.
// Reset (rst, synchronous): clears the parser state and drops m_tvalid.
// The parser also clears itself after every NUL.
// Stall: the result register holds while m_tready is low; s_tready is low
// only while that register is full and not being drained, so characters
// keep streaming whenever the result slot frees in the same cycle.
`default_nettype none
module decimal_number_text_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [0] is_negative, [32:1] mantissa,
                                      // [42:33] decimal_exponent, [47:43] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int MB = dntp_pkg::MANTISSA_BITS;
  localparam int EB = dntp_pkg::EXPONENT_BITS;
  localparam int DW = dntp_pkg::DEXP_W;
  localparam int FW = dntp_pkg::FRAC_W;

  // Parser state
  logic [MB-1:0]               digits_value, digits_value_next;
  logic                        integer_nonzero, integer_nonzero_next;
  logic [FW-1:0]               fraction_count, fraction_count_next;
  logic [EB-1:0]               exponent_value, exponent_value_next;
  dntp_pkg::phase_flags_t      phase_flags, phase_flags_next;
  logic [1:0]                  error_code, error_code_next;

  logic                        accept;
  logic                        is_nul;
  logic [3:0]                  digit;
  logic [MB+3:0]               digits_times10;
  logic [EB+3:0]               exp_times10;
  logic [1:0]                  final_code;
  logic [DW-1:0]               exp_ext, dexp;
  logic [DW+dntp_pkg::OUT_DEXP_W-1:0] dexp_wide;
  logic [MB+dntp_pkg::OUT_MANT_W-1:0] mant_wide;
  logic [dntp_pkg::OUT_DATA_W-1:0]    result_data;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_nul   = (s_tdata == dntp_pkg::CH_NUL);
  assign digit    = 4'(s_tdata - dntp_pkg::CH_0);

  // Multiply by ten as shift-and-add, plus the new digit.
  assign digits_times10 = ({4'b0, digits_value} << 3) + ({4'b0, digits_value} << 1)
                        + {{MB{1'b0}}, digit};
  assign exp_times10    = ({4'b0, exponent_value} << 3) + ({4'b0, exponent_value} << 1)
                        + {{EB{1'b0}}, digit};

  // Per-character state update
  always_comb begin
    digits_value_next    = digits_value;
    integer_nonzero_next = integer_nonzero;
    fraction_count_next  = fraction_count;
    exponent_value_next  = exponent_value;
    phase_flags_next     = phase_flags;
    error_code_next      = error_code;
    if (error_code == dntp_pkg::ST_OK) begin
      case (s_tdata)
        dntp_pkg::CH_MINUS: begin
          if (phase_flags.minus) begin
            error_code_next = dntp_pkg::ST_SYNTAX;
          end else begin
            phase_flags_next.minus = 1'b1;
            if (!integer_nonzero || (phase_flags.exp && exponent_value == '0)) begin
              if (phase_flags.exp) begin
                phase_flags_next.exp_neg = 1'b1;
              end else begin
                phase_flags_next.neg = 1'b1;
              end
            end else begin
              error_code_next = dntp_pkg::ST_SYNTAX;
            end
          end
        end
        dntp_pkg::CH_PLUS: begin
          if (phase_flags.plus) begin
            error_code_next = dntp_pkg::ST_SYNTAX;
          end else begin
            phase_flags_next.plus = 1'b1;
            if (!(!integer_nonzero || (phase_flags.exp && exponent_value == '0))) begin
              error_code_next = dntp_pkg::ST_SYNTAX;
            end
          end
        end
        dntp_pkg::CH_E_LO, dntp_pkg::CH_E_UP: begin
          phase_flags_next.exp = 1'b1;
        end
        dntp_pkg::CH_POINT: begin
          if (phase_flags.point) begin
            error_code_next = dntp_pkg::ST_SYNTAX;
          end else begin
            phase_flags_next.point = 1'b1;
          end
        end
        default: begin
          if (s_tdata inside {[dntp_pkg::CH_0:dntp_pkg::CH_9]}) begin
            if (phase_flags.exp) begin
              // Exponent digit
              phase_flags_next.exp_digit = 1'b1;
              if (exp_times10 > {4'b0, {EB{1'b1}}}) begin
                error_code_next = dntp_pkg::ST_OVERFLOW;
              end else begin
                exponent_value_next = exp_times10[EB-1:0];
              end
            end else if (digits_times10 > {4'b0, {MB{1'b1}}}) begin
              error_code_next = dntp_pkg::ST_OVERFLOW;
            end else begin
              digits_value_next = digits_times10[MB-1:0];
              if (phase_flags.point) begin
                if (fraction_count >= dntp_pkg::FRAC_MAX) begin
                  error_code_next = dntp_pkg::ST_OVERFLOW;
                end else begin
                  fraction_count_next = fraction_count + 1'b1;
                end
              end else if (digit != 4'd0) begin
                integer_nonzero_next = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  // Result at the NUL: check the dangling point or exponent marker
  always_comb begin
    final_code = error_code;
    if (error_code == dntp_pkg::ST_OK) begin
      if ((phase_flags.point && fraction_count == '0) ||
          (phase_flags.exp && !phase_flags.exp_digit)) begin
        final_code = dntp_pkg::ST_SYNTAX;
      end
    end
  end

  assign exp_ext   = {{(DW-EB){1'b0}}, exponent_value};
  assign dexp      = (phase_flags.exp_neg ? (~exp_ext + 1'b1) : exp_ext)
                   - {{(DW-FW){1'b0}}, fraction_count};
  assign dexp_wide = {{dntp_pkg::OUT_DEXP_W{dexp[DW-1]}}, dexp};
  assign mant_wide = {{dntp_pkg::OUT_MANT_W{1'b0}}, digits_value};

  always_comb begin
    result_data = '0;
    if (final_code == dntp_pkg::ST_OK) begin
      result_data[0]     = phase_flags.neg;
      result_data[32:1]  = mant_wide[dntp_pkg::OUT_MANT_W-1:0];
      result_data[42:33] = dexp_wide[dntp_pkg::OUT_DEXP_W-1:0];
    end
  end

  // State registers: advance on each transfer, clear after the NUL
  always_ff @(posedge clk) begin
    if (rst || (accept && is_nul)) begin
      digits_value    <= '0;
      integer_nonzero <= 1'b0;
      fraction_count  <= '0;
      exponent_value  <= '0;
      phase_flags     <= '0;
      error_code      <= dntp_pkg::ST_OK;
    end else if (accept) begin
      digits_value    <= digits_value_next;
      integer_nonzero <= integer_nonzero_next;
      fraction_count  <= fraction_count_next;
      exponent_value  <= exponent_value_next;
      phase_flags     <= phase_flags_next;
      error_code      <= error_code_next;
    end
  end

  // Result register: load on the NUL transfer, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && is_nul) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_nul) begin
      m_tdata <= result_data;
      m_tuser <= final_code;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dntp_checker.sv
`default_nettype none
`include "decimal_number_text_parser_top_defines.svh"
module dntp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  logic in_xfer;
  logic nul_xfer;
  logic out_stall;
  logic payload_ok;
  logic code_ok;

  assign in_xfer    = s_tvalid && s_tready;
  assign nul_xfer   = in_xfer && (s_tdata == dntp_pkg::CH_NUL);
  assign out_stall  = m_tvalid && !m_tready;
  assign payload_ok = (m_tuser == dntp_pkg::ST_OK) || (m_tdata == '0);
  assign code_ok    = m_tuser inside {dntp_pkg::ST_OK, dntp_pkg::ST_SYNTAX,
                                      dntp_pkg::ST_OVERFLOW};

  // A stalled result stays and holds its payload.
  `DNTP_ASSERT_NEXT(a_hold, clk, rst, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // A NUL transfer yields a result in the next cycle.
  `DNTP_ASSERT_NEXT(a_nul_result, clk, rst, nul_xfer, m_tvalid)
  // A non-NUL transfer while the output is not stalled yields no result.
  `DNTP_ASSERT_NEXT(a_no_spurious, clk, rst, in_xfer && !nul_xfer && !out_stall, !m_tvalid)
  // Failed texts carry a zero payload, and status is a defined code.
  `DNTP_ASSERT_NOW(a_err_zero, clk, rst, m_tvalid, payload_ok && code_ok)

endmodule

bind decimal_number_text_parser_top dntp_checker u_dntp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dntp_pkg::*;

  // Cycles without any transfer on either side before the run is abandoned.
  localparam int QUIET_LIMIT = 4000;
  // Length of the long receiver hold-off in the backpressure test.
  localparam int RX_HOLD_CYCLES = 300;
  localparam logic [63:0] MANT_LIMIT =
    (MANTISSA_BITS >= 64) ? '1 : ((64'd1 << MANTISSA_BITS) - 64'd1);
  localparam int unsigned EXP_LIMIT = (1 << EXPONENT_BITS) - 1;

  // One parsed number as it leaves the block.
  typedef struct packed {
    logic [1:0]  status;
    logic        negative;
    logic [31:0] mantissa;
    logic [9:0]  dexp;
  } number_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int chars_sent = 0;
  int mismatch_count = 0;
  logic rx_hold = 1'b0;
  event rx_hold_ev;

  // Parser state mirrored by the predictor.
  logic [63:0]  acc_digits = '0;
  logic         int_nonzero = 1'b0;
  int unsigned  frac_digits = 0;
  int unsigned  exp_mag = 0;
  phase_flags_t flags = '0;
  logic [1:0]   parse_err = ST_OK;

  number_t pending_numbers[$];

  decimal_number_text_parser_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: follow the parser one character at a time.
  // ---------------------------------------------------------------------------

  // Keep the first error of a text; later ones do not replace it.
  function automatic void flag_error(input logic [1:0] code);
    if (parse_err == ST_OK) parse_err = code;
  endfunction

  // A sign is legal once per kind, and only while the integer part is still
  // zero or right after the exponent marker before any nonzero exponent.
  function automatic void take_sign(input logic minus);
    if (minus ? flags.minus : flags.plus) begin
      flag_error(ST_SYNTAX);
      return;
    end
    if (minus) flags.minus = 1'b1;
    else flags.plus = 1'b1;
    if (!int_nonzero || (flags.exp && exp_mag == 0)) begin
      if (minus) begin
        if (flags.exp) flags.exp_neg = 1'b1;
        else flags.neg = 1'b1;
      end
    end else begin
      flag_error(ST_SYNTAX);
    end
  endfunction

  // Route a digit to the exponent, the fraction or the integer part.
  function automatic void take_digit(input int unsigned d);
    if (flags.exp) begin
      flags.exp_digit = 1'b1;
      if (exp_mag > (EXP_LIMIT - d) / 10) flag_error(ST_OVERFLOW);
      else exp_mag = exp_mag * 10 + d;
    end else if (acc_digits > (MANT_LIMIT - 64'(d)) / 64'd10) begin
      flag_error(ST_OVERFLOW);
    end else begin
      acc_digits = acc_digits * 64'd10 + 64'(d);
      if (flags.point) begin
        if (frac_digits >= FRAC_MAX) flag_error(ST_OVERFLOW);
        else frac_digits++;
      end else if (d != 0) begin
        int_nonzero = 1'b1;
      end
    end
  endfunction

  // Advance the mirrored parser by one accepted character; a NUL closes the
  // text, queues the number it stands for and clears the state.
  function automatic void scan_char(input logic [7:0] c);
    number_t num;
    int e;
    if (c == CH_NUL) begin
      if (parse_err == ST_OK &&
          ((flags.point && frac_digits == 0) || (flags.exp && !flags.exp_digit)))
        parse_err = ST_SYNTAX;
      e = int'(exp_mag);
      if (flags.exp_neg) e = -e;
      e = e - int'(frac_digits);
      num = '0;
      num.status = parse_err;
      if (parse_err == ST_OK) begin
        num.negative = flags.neg;
        num.mantissa = acc_digits[31:0];
        num.dexp     = e[9:0];
      end
      pending_numbers.push_back(num);
      acc_digits  = '0;
      int_nonzero = 1'b0;
      frac_digits = 0;
      exp_mag     = 0;
      flags       = '0;
      parse_err   = ST_OK;
    end else if (parse_err == ST_OK) begin
      if (c == CH_MINUS) take_sign(1'b1);
      else if (c == CH_PLUS) take_sign(1'b0);
      else if (c >= CH_0 && c <= CH_9) take_digit(int'(c - CH_0));
      else if (c == CH_E_LO || c == CH_E_UP) flags.exp = 1'b1;
      else if (c == CH_POINT) begin
        if (flags.point) flag_error(ST_SYNTAX);
        else flags.point = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------

  function automatic void report_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatch_count++;
  endfunction

  // Compare one result transfer with the oldest queued number.
  function automatic void check_number();
    number_t want;
    if (pending_numbers.size() == 0) begin
      $display("%0t ns: result with nothing expected, expected none, actual status %0d data %h",
               $time, m_tuser, m_tdata);
      mismatch_count++;
      return;
    end
    want = pending_numbers.pop_front();
    if (m_tuser !== want.status)
      report_field("status", 64'(want.status), 64'(m_tuser));
    if (m_tdata[0] !== want.negative)
      report_field("is_negative", 64'(want.negative), 64'(m_tdata[0]));
    if (m_tdata[32:1] !== want.mantissa)
      report_field("mantissa", 64'(want.mantissa), 64'(m_tdata[32:1]));
    if (m_tdata[42:33] !== want.dexp)
      report_field("decimal_exponent", 64'(want.dexp), 64'(m_tdata[42:33]));
    if (m_tdata[47:43] !== 5'd0)
      report_field("tdata padding", 64'd0, 64'(m_tdata[47:43]));
  endfunction

  // Sample both streams at the edge: predict first, then check.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) scan_char(s_tdata);
      if (m_tvalid && m_tready) check_number();
    end
  end

  // Drive the result ready: random idling, forced low during a hold-off.
  always @(posedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Hold the receiver off for a fixed stretch whenever a test asks for it.
  initial begin
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // Abandon the run when no transfer happens for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout after %0d quiet cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Offer one character, with random idle cycles first; return at the edge
  // of its transfer.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  // Send a whole text and its terminating NUL.
  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
    send_char(CH_NUL);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  // Pick a character that the parser reacts to, or a plain space.
  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(6))
      0: return CH_MINUS;
      1: return CH_PLUS;
      2: return CH_POINT;
      3: return CH_E_LO;
      4: return CH_E_UP;
      5: return 8'h20;
      default: return rand_digit();
    endcase
  endfunction

  // Mostly well-formed numbers with random content, sometimes with a stray
  // symbol inserted; the rest is noise over all non-NUL characters.
  task automatic send_random_text();
    logic [7:0] txt[$];
    int n;
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(3))
        0: txt.push_back(CH_MINUS);
        1: txt.push_back(CH_PLUS);
        default: ;
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 6);
      repeat (n) txt.push_back(rand_digit());
      if ($urandom_range(1) != 0) begin
        txt.push_back(CH_POINT);
        n = $urandom_range(0, 6);
        repeat (n) txt.push_back(rand_digit());
      end
      if ($urandom_range(2) == 0) begin
        txt.push_back(($urandom_range(1) != 0) ? CH_E_LO : CH_E_UP);
        case ($urandom_range(3))
          0: txt.push_back(CH_MINUS);
          1: txt.push_back(CH_PLUS);
          default: ;
        endcase
        n = $urandom_range(0, 3);
        repeat (n) txt.push_back(rand_digit());
      end
      if ($urandom_range(5) == 0) txt.insert($urandom_range(txt.size()), rand_symbol());
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(1) != 0) txt.push_back(rand_symbol());
        else txt.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (txt[i]) send_char(txt[i]);
    send_char(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Field extremes and legal and illegal placements of the symbols.
  task automatic test_directed();
    send_text("");              // empty text: zero
    send_text("0");
    send_text("4294967295");    // largest mantissa
    send_text("4294967296");    // mantissa overflow
    send_text("-12.50e+3");
    send_text("+7.25E-2");
    send_text("1e255");         // largest exponent
    send_text("1e256");         // exponent overflow
    send_text("12-");           // sign after a nonzero integer digit
    send_text("--1");           // second minus
    send_text("-0e-5");         // minus for the exponent after one for the number
    send_text("+-3");           // one of each sign
    send_text("00-7");          // sign while the integer part is still zero
    send_text("1.2.3");         // second point
    send_text("1.");            // point without fraction digits
    send_text("5e");            // exponent marker without digits
    send_text("1e-");
    send_text("3e4E5");         // repeated marker, digits keep going to the exponent
    send_text("7x9 ;");         // ignored characters
    send_text("1.2.-99e");      // characters after an error are dropped
    send_char(8'h01);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(CH_9);
    send_char(CH_NUL);
  endtask

  // Fraction digit count at and past its limit, with the most negative power.
  task automatic test_fraction_limits();
    send_char(CH_0);
    send_char(CH_POINT);
    repeat (64) send_char(CH_0);
    send_char(CH_NUL);
    send_char(CH_POINT);
    repeat (62) send_char(CH_0);
    send_text("1e-255");
  endtask

  task automatic test_random(input int target);
    int start;
    start = chars_sent;
    while (chars_sent - start < target) send_random_text();
  endtask

  // Stall the receiver for a long stretch while texts keep coming, so the
  // result slot fills and the block must stall its input.
  task automatic test_backpressure();
    -> rx_hold_ev;
    repeat (6) send_random_text();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 34;
    rx_idle_pct = 49;
    test_directed();
    test_fraction_limits();
    test_random(350);

    tx_idle_pct = 49;
    rx_idle_pct = 34;
    test_random(350);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(300);
    test_backpressure();

    // Drain: wait for every queued number, then watch for strays.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/dntp_pkg.sv
rtl/decimal_number_text_parser_top.sv
rtl/dntp_checker.sv
verif/testbench.sv
